// ===== rtl/core/edc_pkg.sv =====
`default_nettype none

package edc_pkg;

	localparam int unsigned HdrBytes = 10;
	localparam int unsigned TrlBytes = 4;
	localparam int unsigned MinBytes = 14;
	localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
	localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;
	localparam logic [31:0] MagicReset = 32'h5051_4F42;
	localparam logic [7:0] VersionReset = 8'd1;

	typedef enum logic [2:0] {
		ERR_NONE   = 3'd0,
		ERR_SHORT  = 3'd1,
		ERR_LENGTH = 3'd2,
		ERR_CRC    = 3'd3,
		ERR_HEADER = 3'd4
	} err_t;

	typedef enum logic {
		PH_HEADER = 1'b0,
		PH_BODY   = 1'b1
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_last;
	} env_t;

	typedef struct packed {
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic       frame_end;
		logic       frame_ok;
		logic [2:0] error_code;
		logic [7:0] attempts_out;
	} res_t;

	typedef struct packed {
		logic [31:0] expected_magic;
		logic [7:0]  expected_version;
	} cfg_t;

	// reflected CRC-32, one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/envelope_deframer_crc32.sv =====
// channel   | handshake                    | payload
// ----------+------------------------------+---------------------------------
// env       | env_valid / env_stall        | env (data_byte, frame_last)
// res       | res_valid / res_stall        | res (payload and verdict fields)
// cfg       | APB psel/penable/pwrite      | paddr, pwdata, prdata
//
// One byte per cycle sustained while res is not stalled; a taken byte goes to
// the input register, then via parse and CRC step to the result register.
// Reset clears all frame state and loads the register defaults.
// A held result stalls the input register, which then stalls env.
`default_nettype none

module envelope_deframer_crc32 (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          env_valid,
	output logic               env_stall,
	input  wire edc_pkg::env_t env,
	output logic               res_valid,
	input  wire logic          res_stall,
	output edc_pkg::res_t      res,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [2:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import edc_pkg::*;

	cfg_t  cfg;
	env_t  env_s1;
	logic  valid_s1;
	res_t  res_s2, res_n;
	logic  valid_s2;
	logic  adv, proc, hit, take;

	edc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	edc_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.proc   (proc),
		.env_s1 (env_s1),
		.cfg    (cfg),
		.res    (res_n),
		.hit    (hit)
	);

	assign adv       = !valid_s2 || !res_stall;
	assign proc      = valid_s1 && adv;
	assign env_stall = valid_s1 && !adv;
	assign take      = env_valid && !env_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			env_s1 <= env;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= proc && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			res_s2 <= res_n;
		end
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

endmodule

`default_nettype wire

// ===== rtl/core/edc_cfg.sv =====
`default_nettype none

module edc_cfg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [2:0]       paddr,
	input  wire logic [31:0]      pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output edc_pkg::cfg_t         cfg
);
	import edc_pkg::*;

	typedef enum logic {
		REG_MAGIC   = 1'b0,
		REG_VERSION = 1'b1
	} reg_t;

	logic [31:0] magic_q;
	logic [7:0]  version_q;
	logic        wr;
	reg_t        sel;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;
	// word address; byte lane bits are ignored
	assign sel    = reg_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q   <= MagicReset;
			version_q <= VersionReset;
		end else if (wr) begin
			unique case (sel)
				REG_MAGIC:   magic_q   <= pwdata;
				REG_VERSION: version_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_MAGIC:   prdata = magic_q;
			REG_VERSION: prdata = {24'd0, version_q};
			default:     prdata = 32'd0;
		endcase
	end

	assign cfg.expected_magic   = magic_q;
	assign cfg.expected_version = version_q;

endmodule

`default_nettype wire

// ===== rtl/core/edc_parse.sv =====
`default_nettype none

module edc_parse (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          proc,
	input  wire edc_pkg::env_t env_s1,
	input  wire edc_pkg::cfg_t cfg,
	output edc_pkg::res_t      res,
	output logic               hit
);
	import edc_pkg::*;

	logic [31:0] crc_q, crc_n;
	logic [3:0]  hidx_q, hidx_n;
	phase_t      phase_q, phase_n;
	logic [31:0] dlen_q, dlen_n;
	logic [31:0] pcnt_q, pcnt_n;
	logic [31:0] magic_q, magic_n;
	logic [7:0]  ver_q, ver_n;
	logic [7:0]  att_q, att_n;
	logic [31:0] tword_q, tword_n;
	logic [2:0]  tcnt_q, tcnt_n;
	logic [3:0]  tot_q, tot_n;
	logic        ovr_q, ovr_n;
	logic        pvalid;
	logic [7:0]  b;
	logic [32:0] exp_q33, exp_n33;
	err_t        err;

	assign b       = env_s1.data_byte;
	assign crc_n   = (tcnt_q >= 3'(TrlBytes)) ? crc_byte(crc_q, tword_q[7:0]) : crc_q;
	assign tcnt_n  = (tcnt_q >= 3'(TrlBytes)) ? tcnt_q : tcnt_q + 3'd1;
	assign tword_n = {b, tword_q[31:8]};
	assign tot_n   = (tot_q < 4'(MinBytes)) ? tot_q + 4'd1 : tot_q;
	assign exp_q33 = {1'b0, dlen_q} + 33'(TrlBytes);

	// next state
	always_comb begin
		hidx_n  = hidx_q;
		phase_n = phase_q;
		dlen_n  = dlen_q;
		pcnt_n  = pcnt_q;
		magic_n = magic_q;
		ver_n   = ver_q;
		att_n   = att_q;
		ovr_n   = ovr_q;
		pvalid  = 1'b0;
		if (phase_q == PH_HEADER) begin
			unique case (hidx_q)
				4'd0: magic_n[7:0]   = b;
				4'd1: magic_n[15:8]  = b;
				4'd2: magic_n[23:16] = b;
				4'd3: magic_n[31:24] = b;
				4'd4: ver_n          = b;
				4'd5: att_n          = b;
				4'd6: dlen_n[7:0]    = b;
				4'd7: dlen_n[15:8]   = b;
				4'd8: dlen_n[23:16]  = b;
				4'd9: dlen_n[31:24]  = b;
				default: ;
			endcase
			hidx_n = hidx_q + 4'd1;
			if (hidx_q >= 4'(HdrBytes - 1)) begin
				phase_n = PH_BODY;
			end
		end else begin
			if ({1'b0, pcnt_q} >= exp_q33) begin
				ovr_n = 1'b1;
			end else begin
				pvalid = pcnt_q < dlen_q;
				pcnt_n = pcnt_q + 32'd1;
			end
		end
	end

	assign exp_n33 = {1'b0, dlen_n} + 33'(TrlBytes);

	// verdict and result
	always_comb begin
		priority if (tot_n < 4'(MinBytes)) begin
			err = ERR_SHORT;
		end else if (tword_n != (crc_n ^ CrcInit)) begin
			err = ERR_CRC;
		end else if (magic_n != cfg.expected_magic || ver_n != cfg.expected_version) begin
			err = ERR_HEADER;
		end else if (ovr_n || phase_n != PH_BODY || {1'b0, pcnt_n} != exp_n33) begin
			err = ERR_LENGTH;
		end else begin
			err = ERR_NONE;
		end
		res.payload_valid = pvalid;
		res.payload_byte  = pvalid ? b : 8'd0;
		res.frame_end     = env_s1.frame_last;
		res.frame_ok      = env_s1.frame_last && (err == ERR_NONE);
		res.error_code    = env_s1.frame_last ? err : ERR_NONE;
		res.attempts_out  = (env_s1.frame_last && (err == ERR_NONE)) ? att_n : 8'd0;
		hit               = pvalid || env_s1.frame_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CrcInit;
			hidx_q  <= 4'd0;
			phase_q <= PH_HEADER;
			dlen_q  <= 32'd0;
			pcnt_q  <= 32'd0;
			magic_q <= 32'd0;
			ver_q   <= 8'd0;
			att_q   <= 8'd0;
			tword_q <= 32'd0;
			tcnt_q  <= 3'd0;
			tot_q   <= 4'd0;
			ovr_q   <= 1'b0;
		end else if (proc) begin
			if (env_s1.frame_last) begin
				crc_q   <= CrcInit;
				hidx_q  <= 4'd0;
				phase_q <= PH_HEADER;
				dlen_q  <= 32'd0;
				pcnt_q  <= 32'd0;
				magic_q <= 32'd0;
				ver_q   <= 8'd0;
				att_q   <= 8'd0;
				tword_q <= 32'd0;
				tcnt_q  <= 3'd0;
				tot_q   <= 4'd0;
				ovr_q   <= 1'b0;
			end else begin
				crc_q   <= crc_n;
				hidx_q  <= hidx_n;
				phase_q <= phase_n;
				dlen_q  <= dlen_n;
				pcnt_q  <= pcnt_n;
				magic_q <= magic_n;
				ver_q   <= ver_n;
				att_q   <= att_n;
				tword_q <= tword_n;
				tcnt_q  <= tcnt_n;
				tot_q   <= tot_n;
				ovr_q   <= ovr_n;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/edc_chk.sv =====
`default_nettype none

module edc_chk (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          env_valid,
	input wire logic          env_stall,
	input wire logic          res_valid,
	input wire logic          res_stall,
	input wire edc_pkg::res_t res
);
	import edc_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("held result changed");

	a_res_content: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.payload_valid || res.frame_end)
		else $error("empty result request");

	a_ok_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.frame_ok |-> res.frame_end && res.error_code == ERR_NONE)
		else $error("ok verdict carries error");

	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.frame_end && !res.frame_ok |->
			res.error_code == ERR_SHORT || res.error_code == ERR_LENGTH ||
			res.error_code == ERR_CRC || res.error_code == ERR_HEADER)
		else $error("failed verdict without error code");

	a_no_stall_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid && $past(!res_valid) && $past(!env_valid) |-> !env_stall)
		else $error("input stalled with empty pipeline");

endmodule

bind envelope_deframer_crc32 edc_chk u_chk (.*);

`default_nettype wire
